>>> sv/gha_pkg.sv
// Package: shared constants, operation and status codes, controller states.
package gha_pkg;

	// Default sizing
	localparam int SLOTS_DEF    = 256;
	localparam int GEN_BITS_DEF = 8;

	// Fixed port field widths
	localparam int OP_W    = 2;
	localparam int SIDX_W  = 8;
	localparam int HGEN_W  = 8;
	localparam int STAT_W  = 2;
	localparam int FREED_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_DESTROY = 2'd2,
		OP_FLUSH   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_BAD_HANDLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_POP,
		S_CLAIM,
		S_CHECK,
		S_FLUSH
	} state_t;

endpackage

>>> sv/gha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/generational_handle_allocator_top.sv
// Top level: generational handle allocator with free stack and pending queue.
//
//  channel   handshake                 word
//  --------  ------------------------  ----------------------------------------------
//  command   start / busy              operation, slot_index, handle_generation
//  result    done (one-cycle strobe)   status, slot_out, generation_out, freed_count
//
//  Lookup and destroy read the slot entry, then check it. Create reads the free stack, then
//  the slot entry, and stops after the free stack read when the free stack is empty.
//  Flush walks the pending queue RAM one word a cycle.
//  After reset a clearing pass writes every slot entry, with busy high.
//  One command is in flight at a time; busy stays high until its result is issued.
//  The result strobe is high in the cycle in which busy falls; the receiver cannot stall it.
module generational_handle_allocator_top #(
	parameter int SLOTS    = gha_pkg::SLOTS_DEF,
	parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [gha_pkg::OP_W-1:0]     operation,
	input  logic [gha_pkg::SIDX_W-1:0]   slot_index,
	input  logic [gha_pkg::HGEN_W-1:0]   handle_generation,
	output logic                         done,
	output logic [gha_pkg::STAT_W-1:0]   status,
	output logic [gha_pkg::SIDX_W-1:0]   slot_out,
	output logic [gha_pkg::HGEN_W-1:0]   generation_out,
	output logic [gha_pkg::FREED_W-1:0]  freed_count
);

	import gha_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int SLOT_W = GEN_BITS + 1;

	// Controller and counters
	state_t             state_q, state_d;
	op_t                op_q;
	logic [SIDX_W-1:0]  idx_q;
	logic [HGEN_W-1:0]  hgen_q;
	logic [CNT_W-1:0]   fc_q;      // free stack fill
	logic [CNT_W-1:0]   lw_q;      // lowest fill reached; entries below never written
	logic [CNT_W-1:0]   pc_q;      // pending queue fill
	logic [CNT_W-1:0]   fi_q;      // flush walk position
	logic [CNT_W-1:0]   moved_q;
	logic [IDX_W-1:0]   cs_q;      // slot being claimed by create
	logic [IDX_W-1:0]   clr_q;

	// RAM ports
	logic               fs_we, sl_we, pq_we;
	logic [IDX_W-1:0]   fs_waddr, fs_raddr, sl_waddr, sl_raddr, pq_waddr, pq_raddr;
	logic [IDX_W-1:0]   fs_wdata, fs_rdata, pq_wdata, pq_rdata;
	logic [SLOT_W-1:0]  sl_wdata, sl_rdata;

	// Result word before the output register
	logic               res_valid;
	status_t            res_status;
	logic [SIDX_W-1:0]  res_slot;
	logic [HGEN_W-1:0]  res_gen;
	logic [FREED_W-1:0] res_freed;

	logic               accept;
	logic               idx_ok;
	logic [GEN_BITS-1:0] sl_gen, gen_next;
	logic               sl_live, gen_match;
	logic [IDX_W-1:0]   pop_slot;
	logic               pop_ok, flush_end, flush_push;

	gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_stack (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata)
	);

	gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_tab (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(sl_raddr), .rdata(sl_rdata)
	);

	gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_pend_q (
		.clk(clk), .we(pq_we), .waddr(pq_waddr), .wdata(pq_wdata),
		.raddr(pq_raddr), .rdata(pq_rdata)
	);

	// Decode slot word and handle
	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign idx_ok     = {24'd0, idx_q} < 32'(SLOTS);
	assign sl_gen     = sl_rdata[GEN_BITS-1:0];
	assign sl_live    = sl_rdata[GEN_BITS];
	assign gen_match  = (sl_gen == GEN_BITS'(hgen_q));
	assign gen_next   = sl_gen + 1'b1;
	assign pop_ok     = (fc_q != '0);
	assign pop_slot   = (fc_q == lw_q) ? IDX_W'(fc_q - 1'b1) : fs_rdata;
	assign flush_end  = (fi_q == pc_q);
	assign flush_push = !flush_end && (fc_q < CNT_W'(SLOTS));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == IDX_W'(SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_CREATE: state_d = S_POP;
						OP_FLUSH:  state_d = S_FLUSH;
						default:   state_d = S_CHECK;
					endcase
				end
			end
			S_POP:   state_d = pop_ok ? S_CLAIM : S_IDLE;
			S_CLAIM: state_d = S_IDLE;
			S_CHECK: state_d = S_IDLE;
			S_FLUSH: begin
				if (flush_end) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM control and result word
	always_comb begin
		fs_we      = 1'b0;
		fs_waddr   = IDX_W'(fc_q);
		fs_wdata   = pq_rdata;
		fs_raddr   = IDX_W'(fc_q - 1'b1);
		sl_we      = 1'b0;
		sl_waddr   = IDX_W'(idx_q);
		sl_wdata   = {1'b0, gen_next};
		sl_raddr   = IDX_W'(slot_index);
		pq_we      = 1'b0;
		pq_waddr   = IDX_W'(pc_q);
		pq_wdata   = IDX_W'(idx_q);
		pq_raddr   = '0;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_slot   = idx_q;
		res_gen    = '0;
		res_freed  = '0;
		case (state_q)
			S_CLEAR: begin
				sl_we    = 1'b1;
				sl_waddr = clr_q;
				sl_wdata = '0;
			end
			S_POP: begin
				sl_raddr = pop_slot;
				if (!pop_ok) begin
					res_valid  = 1'b1;
					res_status = ST_NO_FREE;
					res_slot   = '0;
				end
			end
			S_CLAIM: begin
				sl_we     = 1'b1;
				sl_waddr  = cs_q;
				sl_wdata  = {1'b1, sl_gen};
				res_valid = 1'b1;
				res_slot  = SIDX_W'(cs_q);
				res_gen   = HGEN_W'(sl_gen);
			end
			S_CHECK: begin
				res_valid = 1'b1;
				if (!idx_ok) begin
					res_status = ST_BAD_HANDLE;
				end else if (!sl_live || !gen_match) begin
					res_status = ST_BAD_HANDLE;
					res_gen    = HGEN_W'(sl_gen);
				end else if (op_q == OP_DESTROY) begin
					sl_we   = 1'b1;
					pq_we   = (pc_q < CNT_W'(SLOTS));
					res_gen = HGEN_W'(gen_next);
				end else begin
					res_gen = HGEN_W'(sl_gen);
				end
			end
			S_FLUSH: begin
				pq_raddr = IDX_W'(fi_q + 1'b1);
				fs_we    = flush_push;
				if (flush_end) begin
					res_valid = 1'b1;
					res_slot  = '0;
					res_freed = FREED_W'(moved_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Advance controller and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			fc_q    <= CNT_W'(SLOTS);
			lw_q    <= CNT_W'(SLOTS);
			pc_q    <= '0;
			fi_q    <= '0;
			moved_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_valid;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) begin
				fi_q    <= '0;
				moved_q <= '0;
			end
			if (state_q == S_POP && pop_ok) begin
				fc_q <= fc_q - 1'b1;
				if (fc_q == lw_q) lw_q <= fc_q - 1'b1;
			end
			if (pq_we) pc_q <= pc_q + 1'b1;
			if (state_q == S_FLUSH) begin
				if (flush_end) begin
					pc_q <= '0;
				end else begin
					fi_q <= fi_q + 1'b1;
				end
				if (flush_push) begin
					fc_q    <= fc_q + 1'b1;
					moved_q <= moved_q + 1'b1;
				end
			end
		end
	end

	// Hold command word and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			idx_q  <= slot_index;
			hgen_q <= handle_generation;
		end
		if (state_q == S_POP) cs_q <= pop_slot;
		if (res_valid) begin
			status         <= res_status;
			slot_out       <= res_slot;
			generation_out <= res_gen;
			freed_count    <= res_freed;
		end
	end

endmodule

>>> sv/gha_checker.sv
// Port checker for the handle allocator, bound to the top level.
module gha_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [gha_pkg::STAT_W-1:0]   status,
	input logic [gha_pkg::SIDX_W-1:0]   slot_out,
	input logic [gha_pkg::HGEN_W-1:0]   generation_out,
	input logic [gha_pkg::FREED_W-1:0]  freed_count
);

	import gha_pkg::*;

	// An accepted word keeps the block busy and brings no result next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not hold busy");

	// A result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without prior work");

	// Status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_NO_FREE || status == ST_BAD_HANDLE))
		else $error("undefined status code");

	// Empty free stack gives an all-zero result
	a_no_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NO_FREE |->
			slot_out == '0 && generation_out == '0 && freed_count == '0)
		else $error("failed create carries data");

	// Freed slots only come from a successful flush
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && freed_count != '0 |-> status == ST_OK && slot_out == '0)
		else $error("freed count on a non-flush result");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.slot_out       (slot_out),
	.generation_out (generation_out),
	.freed_count    (freed_count)
);
